>>> rtl/csr_bfr_pkg.sv
// Shared types, sizes and codes for the CSR breadth-first reach block.
// Used by csr_bfr_walk and csr_breadth_first_reach_core; depends on nothing else.
package csr_bfr_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int MAX_EDGES    = 8192;

    localparam int VID_W  = $clog2(MAX_VERTICES);       // vertex id
    localparam int CNT_W  = $clog2(MAX_VERTICES) + 1;   // vertex count
    localparam int EIDX_W = $clog2(MAX_EDGES);          // neighbor address
    localparam int EVAL_W = $clog2(MAX_EDGES) + 1;      // offset or neighbor value
    localparam int OFF_AW = $clog2(MAX_VERTICES + 1);   // offset table address

    localparam logic [1:0] ACT_LOAD_OFF = 2'd0;
    localparam logic [1:0] ACT_LOAD_NBR = 2'd1;
    localparam logic [1:0] ACT_SEARCH   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_START = 2'd1;
    localparam logic [1:0] ST_BAD_ENTRY = 2'd2;

    typedef struct packed {
        logic [1:0]        action;
        logic [EIDX_W-1:0] entry_index;
        logic [EVAL_W-1:0] entry_value;
        logic [VID_W-1:0]  start_vertex;
    } in_word_t;

    typedef struct packed {
        logic [CNT_W-1:0] reached_count;
        logic [1:0]       status;
    } out_word_t;

    typedef struct packed {
        logic      valid;
        out_word_t word;
    } walk_res_t;

endpackage

>>> rtl/csr_bfr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module csr_bfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/csr_bfr_walk.sv
// Search sequencer: table memories, visited map, vertex queue and one shared comparator.
// Depends on csr_bfr_pkg and csr_bfr_ram.
module csr_bfr_walk
    import csr_bfr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_word_t         in_data,
    input  logic [CNT_W-1:0] nv,
    output walk_res_t        res,
    input  logic             res_ack
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLEAR = 4'd1;
    localparam logic [3:0] S_SEED  = 4'd2;
    localparam logic [3:0] S_NEXT  = 4'd3;
    localparam logic [3:0] S_QRD   = 4'd4;
    localparam logic [3:0] S_OFFLO = 4'd5;
    localparam logic [3:0] S_OFFHI = 4'd6;
    localparam logic [3:0] S_SCAN  = 4'd7;
    localparam logic [3:0] S_NB    = 4'd8;
    localparam logic [3:0] S_VIS   = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    localparam logic [EVAL_W-1:0] EDGE_LIMIT = EVAL_W'(MAX_EDGES);
    localparam logic [EIDX_W-1:0] OFF_LIMIT  = EIDX_W'(MAX_VERTICES);

    logic [3:0]        state_reg, state_next;
    logic [CNT_W-1:0]  clr_reg, clr_next;
    logic [CNT_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  tail_reg, tail_next;
    logic [1:0]        status_reg, status_next;
    logic [VID_W-1:0]  start_reg, start_next;
    logic [VID_W-1:0]  u_reg, u_next;
    logic [VID_W-1:0]  v_reg, v_next;
    logic [EVAL_W-1:0] lo_reg, lo_next;
    logic [EVAL_W-1:0] hi_reg, hi_next;
    logic [EVAL_W-1:0] j_reg, j_next;

    // Shared magnitude comparator.
    logic [EVAL_W-1:0] cmp_a, cmp_b;
    logic              cmp_lt;

    logic              accept;

    logic              off_we;
    logic [OFF_AW-1:0] off_raddr;
    logic [EVAL_W-1:0] off_rdata;
    logic              nb_we;
    logic [EIDX_W-1:0] nb_raddr;
    logic [EVAL_W-1:0] nb_rdata;
    logic              vis_we;
    logic [VID_W-1:0]  vis_waddr;
    logic              vis_wdata;
    logic [VID_W-1:0]  vis_raddr;
    logic              vis_rdata;
    logic              q_we;
    logic [VID_W-1:0]  q_waddr;
    logic [VID_W-1:0]  q_wdata;
    logic [VID_W-1:0]  q_raddr;
    logic [VID_W-1:0]  q_rdata;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    assign off_we = accept && (in_data.action == ACT_LOAD_OFF)
                    && (in_data.entry_index <= OFF_LIMIT);
    assign nb_we  = accept && (in_data.action == ACT_LOAD_NBR);

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                cmp_a = EVAL_W'(in_data.start_vertex);
                cmp_b = EVAL_W'(nv);
            end
            S_CLEAR:
            begin
                cmp_a = EVAL_W'(clr_reg);
                cmp_b = EVAL_W'(nv);
            end
            S_NEXT:
            begin
                cmp_a = EVAL_W'(head_reg);
                cmp_b = EVAL_W'(tail_reg);
            end
            S_SCAN:
            begin
                cmp_a = j_reg;
                cmp_b = hi_reg;
            end
            S_NB:
            begin
                cmp_a = nb_rdata;
                cmp_b = EVAL_W'(nv);
            end
            default:
            begin
                cmp_a = '0;
                cmp_b = '0;
            end
        endcase
    end

    assign cmp_lt = (cmp_a < cmp_b);

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        status_next = status_reg;
        start_next  = start_reg;
        u_next      = u_reg;
        v_next      = v_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        j_next      = j_reg;

        off_raddr = OFF_AW'(u_reg);
        nb_raddr  = j_reg[EIDX_W-1:0];
        vis_raddr = nb_rdata[VID_W-1:0];
        q_raddr   = head_reg[VID_W-1:0];
        vis_we    = 1'b0;
        vis_waddr = clr_reg[VID_W-1:0];
        vis_wdata = 1'b0;
        q_we      = 1'b0;
        q_waddr   = tail_reg[VID_W-1:0];
        q_wdata   = v_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (in_data.action == ACT_SEARCH))
                begin
                    start_next = in_data.start_vertex;
                    if (cmp_lt)
                    begin
                        clr_next   = '0;
                        state_next = S_CLEAR;
                    end
                    else
                    begin
                        tail_next   = '0;
                        status_next = ST_BAD_START;
                        state_next  = S_DONE;
                    end
                end
            end
            S_CLEAR:
            begin
                // Only ids below the vertex count are ever looked up.
                if (cmp_lt)
                begin
                    vis_we   = 1'b1;
                    clr_next = clr_reg + 1'b1;
                end
                else
                begin
                    state_next = S_SEED;
                end
            end
            S_SEED:
            begin
                vis_we      = 1'b1;
                vis_waddr   = start_reg;
                vis_wdata   = 1'b1;
                q_we        = 1'b1;
                q_waddr     = '0;
                q_wdata     = start_reg;
                head_next   = '0;
                tail_next   = CNT_W'(1);
                status_next = ST_OK;
                state_next  = S_NEXT;
            end
            S_NEXT:
            begin
                if (cmp_lt)
                begin
                    head_next  = head_reg + 1'b1;
                    state_next = S_QRD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_QRD:
            begin
                off_raddr  = OFF_AW'(q_rdata);
                u_next     = q_rdata;
                state_next = S_OFFLO;
            end
            S_OFFLO:
            begin
                off_raddr  = OFF_AW'(u_reg) + 1'b1;
                lo_next    = off_rdata;
                state_next = S_OFFHI;
            end
            S_OFFHI:
            begin
                if ((lo_reg > EDGE_LIMIT) || (off_rdata > EDGE_LIMIT))
                begin
                    status_next = ST_BAD_ENTRY;
                    state_next  = S_NEXT;
                end
                else
                begin
                    j_next     = lo_reg;
                    hi_next    = off_rdata;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (cmp_lt)
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_NB;
                end
                else
                begin
                    state_next = S_NEXT;
                end
            end
            S_NB:
            begin
                if (cmp_lt)
                begin
                    v_next     = nb_rdata[VID_W-1:0];
                    state_next = S_VIS;
                end
                else
                begin
                    status_next = ST_BAD_ENTRY;
                    state_next  = S_SCAN;
                end
            end
            S_VIS:
            begin
                if (!vis_rdata)
                begin
                    vis_we    = 1'b1;
                    vis_waddr = v_reg;
                    vis_wdata = 1'b1;
                    q_we      = 1'b1;
                    tail_next = tail_reg + 1'b1;
                end
                state_next = S_SCAN;
            end
            S_DONE:
            begin
                if (res_ack)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            clr_reg    <= '0;
            head_reg   <= '0;
            tail_reg   <= '0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        u_reg     <= u_next;
        v_reg     <= v_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        j_reg     <= j_next;
    end

    assign res.valid              = (state_reg == S_DONE);
    assign res.word.reached_count = tail_reg;
    assign res.word.status        = status_reg;

    csr_bfr_ram #(.WIDTH(EVAL_W), .DEPTH(MAX_VERTICES + 1)) u_offset_ram (
        .clk   (clk),
        .we    (off_we),
        .waddr (in_data.entry_index[OFF_AW-1:0]),
        .wdata (in_data.entry_value),
        .raddr (off_raddr),
        .rdata (off_rdata)
    );

    csr_bfr_ram #(.WIDTH(EVAL_W), .DEPTH(MAX_EDGES)) u_neighbor_ram (
        .clk   (clk),
        .we    (nb_we),
        .waddr (in_data.entry_index),
        .wdata (in_data.entry_value),
        .raddr (nb_raddr),
        .rdata (nb_rdata)
    );

    csr_bfr_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_visited_ram (
        .clk   (clk),
        .we    (vis_we),
        .waddr (vis_waddr),
        .wdata (vis_wdata),
        .raddr (vis_raddr),
        .rdata (vis_rdata)
    );

    csr_bfr_ram #(.WIDTH(VID_W), .DEPTH(MAX_VERTICES)) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

`ifndef ASSERT_OFF
    // Once the queue is seeded, its head never passes the tail.
    a_head_le_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg >= S_NEXT && state_reg <= S_VIS) |-> (head_reg <= tail_reg))
        else $error("queue head ran past tail");

    // A vertex is only looked up in the visited map when its id is in range.
    a_vis_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_VIS) |-> (CNT_W'(v_reg) < nv))
        else $error("visited lookup with out of range id");

    // A result without a bad start always counts at least the start vertex and never more than nv.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.word.status != ST_BAD_START) |->
        (res.word.reached_count >= CNT_W'(1) && res.word.reached_count <= nv))
        else $error("reach count out of range");

    // A search with a valid start always begins with the clearing sweep.
    a_search_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_data.action == ACT_SEARCH && CNT_W'(in_data.start_vertex) < nv)
        |=> (state_reg == S_CLEAR))
        else $error("search skipped visited clear");
`endif

endmodule

>>> rtl/csr_breadth_first_reach_core.sv
// Breadth-first reachability over a CSR graph. Loads: accepted one word per cycle while no search
// is running, no result. Search: a clear sweep of the visited map for the first nv vertices, then
// a walk of the queue over the offset and neighbor tables that skips a vertex with bad offsets
// and any out-of-range neighbor entry; nv is min(vertex_count, 1024).
// A bad start vertex skips the clear sweep and the walk; input stalls until the result is taken.
// Reset (rst_n, async, active low) clears control state and sets vertex_count to 1.
module csr_breadth_first_reach_core
    import csr_bfr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CNT_W-1:0] cfg_wr_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_word_t         in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output out_word_t        out_data
);

    logic [CNT_W-1:0] vertex_count_reg, vertex_count_next;
    logic [CNT_W-1:0] nv;
    logic             out_valid_reg, out_valid_next;
    out_word_t        out_data_reg, out_data_next;
    walk_res_t        res;
    logic             res_ack;

    assign vertex_count_next = cfg_wr_en ? cfg_wr_data : vertex_count_reg;
    assign nv = (vertex_count_reg > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
                                                          : vertex_count_reg;

    // The output register takes a result whenever it is empty or being drained.
    assign res_ack = res.valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        if (res_ack)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res.word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= CNT_W'(1);
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            vertex_count_reg <= vertex_count_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    csr_bfr_walk u_walk (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .nv       (nv),
        .res      (res),
        .res_ack  (res_ack)
    );

endmodule

>>> verif/csr_breadth_first_reach_core_test.sv
`timescale 1ns / 1ps
// Self-checking bench for csr_breadth_first_reach_core: a directed table, then random phases.
// Depends on csr_bfr_pkg and the core; predicts search results in SystemVerilog, apart from typed rows.
module csr_breadth_first_reach_core_test;
    import csr_bfr_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int VAL_MAX        = (1 << EVAL_W) - 1;

    typedef struct {
        bit               is_cfg;
        logic [CNT_W-1:0] cfg_value;
        in_word_t         word;
        bit               typed;
        out_word_t        typed_res;
    } stim_row_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_wr_en = 1'b0;
    logic [CNT_W-1:0] cfg_wr_data = '0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    in_word_t         in_data = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    out_word_t        out_data;

    // Shadow of the block: tables, which entries hold loaded data, and the vertex count.
    logic [EVAL_W-1:0] off_tab [0:MAX_VERTICES];
    bit                off_set [0:MAX_VERTICES];
    logic [EVAL_W-1:0] nbr_tab [0:MAX_EDGES-1];
    bit                nbr_set [0:MAX_EDGES-1];
    logic [CNT_W-1:0]  vcount_reg = CNT_W'(1);
    bit                seen [0:MAX_VERTICES-1];
    int unsigned       frontier [0:MAX_VERTICES-1];

    out_word_t awaited_reach [$];
    stim_row_t stim_rows [$];
    int        mismatches = 0;
    int        quiet_cycles = 0;
    bit        idle_on = 1'b0;
    int        stall_left = 0;

    always #6 clk = ~clk;

    csr_breadth_first_reach_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

    // Breadth-first walk on the shadow tables. Returns 0 when the walk would read an
    // entry that was never loaded, so such a search is never sent.
    function automatic bit reach_from(input int unsigned root, output out_word_t res);
        int unsigned nv, head, tail, u, lo, hi, j, v, cnt, i;
        logic [1:0]  st;
        bit          ok;
        nv = (vcount_reg > MAX_VERTICES) ? MAX_VERTICES : vcount_reg;
        ok = 1'b1;
        if (root >= nv)
        begin
            res.reached_count = '0;
            res.status = ST_BAD_START;
            return 1'b1;
        end
        for (i = 0; i < MAX_VERTICES; i++)
            seen[i] = 1'b0;
        st = ST_OK;
        seen[root] = 1'b1;
        frontier[0] = root;
        head = 0;
        tail = 1;
        cnt = 1;
        while (head < tail)
        begin
            u = frontier[head];
            head++;
            if (!off_set[u] || !off_set[u + 1])
                ok = 1'b0;
            lo = off_tab[u];
            hi = off_tab[u + 1];
            if (lo > MAX_EDGES || hi > MAX_EDGES)
                st = ST_BAD_ENTRY;
            else
                for (j = lo; j < hi; j++)
                begin
                    if (!nbr_set[j])
                        ok = 1'b0;
                    v = nbr_tab[j];
                    if (v >= nv)
                        st = ST_BAD_ENTRY;
                    else if (!seen[v])
                    begin
                        seen[v] = 1'b1;
                        frontier[tail] = v;
                        tail++;
                        cnt++;
                    end
                end
        end
        res.reached_count = cnt[CNT_W-1:0];
        res.status = st;
        return ok;
    endfunction

    function automatic in_word_t random_word();
        in_word_t w;
        w.action       = 2'($urandom_range(0, 3));
        w.entry_index  = EIDX_W'($urandom_range(0, MAX_EDGES - 1));
        w.entry_value  = EVAL_W'($urandom_range(0, VAL_MAX));
        w.start_vertex = VID_W'($urandom_range(0, MAX_VERTICES - 1));
        return w;
    endfunction

    // Neighbor id: mostly inside the live window, now and then out of range.
    function automatic int nbr_pick(input int nv, input int base, input int k);
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(nv, VAL_MAX);
        return base + $urandom_range(0, k - 1);
    endfunction

    function automatic stim_row_t row_item(input logic [1:0] act, input int idx, input int val,
                                           input int sv);
        stim_row_t r;
        r = '{default: '0};
        r.word.action = act;
        r.word.entry_index = EIDX_W'(idx);
        r.word.entry_value = EVAL_W'(val);
        r.word.start_vertex = VID_W'(sv);
        return r;
    endfunction

    function automatic stim_row_t row_reach(input int sv, input int cnt, input logic [1:0] st);
        stim_row_t r;
        r = row_item(ACT_SEARCH, 0, 0, sv);
        r.typed = 1'b1;
        r.typed_res.reached_count = CNT_W'(cnt);
        r.typed_res.status = st;
        return r;
    endfunction

    function automatic stim_row_t row_cfg(input int v);
        stim_row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.cfg_value = CNT_W'(v);
        return r;
    endfunction

    function automatic void add_row(input stim_row_t r);
        stim_rows.insert(stim_rows.size(), r);
    endfunction

    task automatic apply_word(input in_word_t w, input bit typed, input out_word_t typed_res);
        out_word_t res;
        case (w.action)
            ACT_LOAD_OFF:
                if (w.entry_index <= MAX_VERTICES)
                begin
                    off_tab[w.entry_index] = w.entry_value;
                    off_set[w.entry_index] = 1'b1;
                end
            ACT_LOAD_NBR:
            begin
                nbr_tab[w.entry_index] = w.entry_value;
                nbr_set[w.entry_index] = 1'b1;
            end
            ACT_SEARCH:
            begin
                void'(reach_from(w.start_vertex, res));
                awaited_reach.insert(awaited_reach.size(), typed ? typed_res : res);
            end
            default: ;
        endcase
    endtask

    // Offers one word, waits for it to be taken, then updates the shadow.
    task automatic push_word(input in_word_t w, input bit typed, input out_word_t typed_res);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_data <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        apply_word(w, typed, typed_res);
    endtask

    task automatic load_word(input logic [1:0] act, input int idx, input int val);
        in_word_t w;
        w = random_word();
        w.action = act;
        w.entry_index = EIDX_W'(idx);
        w.entry_value = EVAL_W'(val);
        push_word(w, 1'b0, '0);
    endtask

    // Loads leave no result behind, so a short settle follows the last search result.
    task automatic drain_block();
        in_valid <= 1'b0;
        while (awaited_reach.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_vcount(input logic [CNT_W-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        vcount_reg = v;
    endtask

    // One setting of the vertex count: load a small CSR window of live vertices, then mix
    // searches with edits of the tables and words the block ignores.
    task automatic run_phase(input int vc_value, input int kmax, input int n_words);
        int        nv, k, base, eb, e_cnt, cum, sent, pick, i;
        in_word_t  w;
        out_word_t scratch;
        drain_block();
        write_vcount(CNT_W'(vc_value));
        nv = (vc_value > MAX_VERTICES) ? MAX_VERTICES : vc_value;
        k = (nv == 0) ? 0 : $urandom_range(1, (kmax < nv) ? kmax : nv);
        case ($urandom_range(0, 2))
            0: base = 0;
            1: base = nv - k;
            default: base = $urandom_range(0, nv - k);
        endcase
        eb = $urandom_range(0, MAX_EDGES - 4 * k);
        cum = 0;
        if (k > 0)
            for (i = 0; i <= k; i++)
            begin
                load_word(ACT_LOAD_OFF, base + i, eb + cum);
                if (i < k)
                    cum += $urandom_range(0, 4);
            end
        e_cnt = cum;
        for (i = 0; i < e_cnt; i++)
            load_word(ACT_LOAD_NBR, eb + i, nbr_pick(nv, base, k));

        sent = 0;
        while (sent < n_words)
        begin
            w = random_word();
            pick = $urandom_range(0, 99);
            if (pick < 50 || (k == 0 && pick < 70))
            begin
                w.action = ACT_SEARCH;
                if (k > 0 && $urandom_range(0, 4) != 0)
                    w.start_vertex = VID_W'(base + $urandom_range(0, k - 1));
                if (!reach_from(w.start_vertex, scratch) && k > 0)
                    w.start_vertex = VID_W'(base + $urandom_range(0, k - 1));
                if (!reach_from(w.start_vertex, scratch))
                    continue;
            end
            else if (pick < 62)
            begin
                if (e_cnt > 0)
                begin
                    w.action = ACT_LOAD_NBR;
                    w.entry_index = EIDX_W'(eb + $urandom_range(0, e_cnt - 1));
                    w.entry_value = EVAL_W'(nbr_pick(nv, base, k));
                end
                else
                    w.action = 2'd3;
            end
            else if (pick < 70)
            begin
                // Offsets past the edge store, or reversed against the next entry.
                w.action = ACT_LOAD_OFF;
                w.entry_index = EIDX_W'(base + $urandom_range(0, k));
                if ($urandom_range(0, 1) == 0)
                    w.entry_value = EVAL_W'($urandom_range(MAX_EDGES + 1, VAL_MAX));
                else
                    w.entry_value = EVAL_W'(eb + $urandom_range(0, e_cnt));
            end
            else if (pick < 76)
            begin
                w.action = ACT_LOAD_OFF;
                w.entry_index = EIDX_W'($urandom_range(MAX_VERTICES + 1, MAX_EDGES - 1));
            end
            else if (pick < 84)
                w.action = ACT_LOAD_NBR;
            else if (pick < 92)
                w.action = 2'd3;
            else
            begin
                w.action = ACT_LOAD_OFF;
                w.entry_index = EIDX_W'($urandom_range(0, MAX_VERTICES));
            end
            push_word(w, 1'b0, '0);
            sent++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
            stall_left <= stall_left - 1;
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 15);
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin : reach_check
        out_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_reach.size() == 0)
            begin
                $display("%0t: unexpected result, got count %0d status %0d", $time,
                         out_data.reached_count, out_data.status);
                mismatches++;
            end
            else
            begin
                want = awaited_reach.pop_front();
                if (out_data.reached_count !== want.reached_count)
                begin
                    $display("%0t: reached_count expected %0d, got %0d", $time,
                             want.reached_count, out_data.reached_count);
                    mismatches++;
                end
                if (out_data.status !== want.status)
                begin
                    $display("%0t: status expected %0d, got %0d", $time,
                             want.status, out_data.status);
                    mismatches++;
                end
            end
        end
    end

    // Any word moved on either channel, or a register write, counts as progress.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("[csr_breadth_first_reach_core] ERROR");
            $finish;
        end
    end

    initial
    begin : main_seq
        int ph;
        add_row(row_item(ACT_LOAD_OFF, 0, 0, 0));
        add_row(row_item(ACT_LOAD_OFF, 1, 0, 0));
        add_row(row_reach(0, 1, ST_OK));
        add_row(row_reach(1, 0, ST_BAD_START));
        add_row(row_reach(MAX_VERTICES - 1, 0, ST_BAD_START));
        add_row(row_item(2'd3, MAX_EDGES - 1, VAL_MAX, MAX_VERTICES - 1));
        add_row(row_item(ACT_LOAD_OFF, MAX_EDGES - 1, VAL_MAX, 0));
        add_row(row_item(ACT_LOAD_OFF, MAX_VERTICES + 1, VAL_MAX, 0));
        add_row(row_item(ACT_LOAD_OFF, MAX_VERTICES, MAX_EDGES, 0));
        add_row(row_item(ACT_LOAD_NBR, MAX_EDGES - 1, VAL_MAX, 0));
        // Four vertices: 0 -> {1,3}, 1 -> {2}, 2 -> {}, 3 -> {0, out of range}.
        add_row(row_cfg(4));
        add_row(row_item(ACT_LOAD_OFF, 0, 0, 0));
        add_row(row_item(ACT_LOAD_OFF, 1, 2, 0));
        add_row(row_item(ACT_LOAD_OFF, 2, 3, 0));
        add_row(row_item(ACT_LOAD_OFF, 3, 3, 0));
        add_row(row_item(ACT_LOAD_OFF, 4, 5, 0));
        add_row(row_item(ACT_LOAD_NBR, 0, 1, 0));
        add_row(row_item(ACT_LOAD_NBR, 1, 3, 0));
        add_row(row_item(ACT_LOAD_NBR, 2, 2, 0));
        add_row(row_item(ACT_LOAD_NBR, 3, 0, 0));
        add_row(row_item(ACT_LOAD_NBR, 4, VAL_MAX, 0));
        add_row(row_item(ACT_SEARCH, 0, 0, 0));
        add_row(row_item(ACT_LOAD_OFF, 2, MAX_EDGES + 1, 0));
        add_row(row_item(ACT_SEARCH, 0, 0, 2));
        add_row(row_item(ACT_LOAD_OFF, 3, 7, 0));
        add_row(row_item(ACT_SEARCH, 0, 0, 3));
        add_row(row_cfg(0));
        add_row(row_reach(0, 0, ST_BAD_START));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_on <= 1'b1;

        foreach (stim_rows[i])
        begin
            if (stim_rows[i].is_cfg)
            begin
                drain_block();
                write_vcount(stim_rows[i].cfg_value);
            end
            else
                push_word(stim_rows[i].word, stim_rows[i].typed, stim_rows[i].typed_res);
        end

        for (ph = 0; ph < 12; ph++)
        begin
            idle_on <= (ph < 9) && (ph % 3 != 2);
            case (ph)
                0: run_phase((1 << CNT_W) - 1, 16, 100);
                1: run_phase(0, 1, 40);
                2: run_phase(1, 1, 80);
                3: run_phase(MAX_VERTICES, 24, 100);
                4: run_phase(2, 2, 120);
                5: run_phase(MAX_VERTICES - 1, 24, 100);
                default: run_phase($urandom_range(3, 64), 48, 130);
            endcase
        end

        idle_on <= 1'b0;
        drain_block();
        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && awaited_reach.size() == 0)
            $display("[csr_breadth_first_reach_core] OK");
        else
            $display("[csr_breadth_first_reach_core] ERROR");
        $finish;
    end

endmodule
